>>> hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// Critically damped smoother package
// Shared types and fixed constants for the smoothing step sequencer.
// ----------------------------------------------------------------------------
package cds_pkg;

	// Sequencer states, one-hot coded.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_WB   = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// Operations of one smoothing step, in the order they run.
	typedef enum logic [3:0] {
		OP_OMEGA = 4'd0,
		OP_X     = 4'd1,
		OP_X2    = 4'd2,
		OP_X3    = 4'd3,
		OP_T1    = 4'd4,
		OP_T2    = 4'd5,
		OP_E     = 4'd6,
		OP_MC    = 4'd7,
		OP_Q1    = 4'd8,
		OP_TEMP  = 4'd9,
		OP_Q2    = 4'd10,
		OP_NVEL  = 4'd11,
		OP_Q3    = 4'd12
	} op_t;

	// Register indexes of the configuration port.
	localparam logic CFG_SMOOTH_TIME = 1'b0;
	localparam logic CFG_MAX_SPEED   = 1'b1;

	// The multiplier retires one radix-4 digit of a 32-bit operand per cycle.
	localparam int MUL_DIGITS = 16;
	localparam int CNT_W      = 6;
	localparam int DEN_W      = 40;

	localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

endpackage

>>> hdl/critically_damped_smoother.sv
// ----------------------------------------------------------------------------
// Critically damped smoother
// One critically damped spring step per input word, in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// An input word (current_pos, target_pos, time_step) is taken on in_valid and
// in_ready. The block holds one velocity and returns one output word
// (new_pos, new_velocity, overshoot_pinned) on out_valid and out_ready.
// smooth_time and max_speed are written through cfg_we, cfg_index and cfg_data;
// the user writes them only while the block is idle, which is not enforced.
// Each step runs thirteen operations on one shared unsigned multiplier that
// takes a radix-4 digit per cycle and one restoring divider that takes one
// quotient bit per cycle. Each operation is framed by a setup state (ST_LOAD)
// and a write-back state (ST_WB). One word is in work at a time, so a new
// word is taken only after the previous step has moved into the output
// register.
// The result sits in an output register, so a new word is taken while the
// previous result waits; a stalled receiver then holds the finished step
// until the register frees.
// Reset clears the velocity to zero, sets smooth_time to 1.0 and max_speed
// to unlimited, and leaves the block idle with no word pending.
// ----------------------------------------------------------------------------
module critically_damped_smoother #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] current_pos,
	input  logic signed [31:0] target_pos,
	input  logic [30:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] new_pos,
	output logic signed [31:0] new_velocity,
	output logic        overshoot_pinned,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);
	import cds_pkg::*;

	localparam int DW = 2 * FRAC_BITS + 2;
	localparam longint ONE_L = 64'd1 << FRAC_BITS;
	localparam longint MIN_ST_R = (ONE_L + 5000) / 10000;
	localparam logic [30:0] MIN_ST = (MIN_ST_R < 1) ? 31'd1 : 31'(MIN_ST_R);
	localparam logic [31:0] C48 = 32'((48 * ONE_L + 50) / 100);
	localparam logic [31:0] C235 = 32'((235 * ONE_L + 500) / 1000);
	localparam logic [DEN_W-1:0] ONE_D = DEN_W'(ONE_L);
	localparam logic [DW-1:0] DVD_OMEGA = DW'(1) << (2 * FRAC_BITS + 1);
	localparam logic [DW-1:0] DVD_E = DW'(1) << (2 * FRAC_BITS);

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			r = S32_MAX;
		end else if (v < -64'sh8000_0000) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	state_t state_q;
	op_t    op_q;
	logic [CNT_W-1:0] cnt_q;

	logic [30:0] smooth_time_q, max_speed_q;
	logic [31:0] vel_q;

	logic [31:0] cur_q, tgt_q;
	logic [30:0] dt_q, st_q, omega_q, x_q;
	logic [31:0] x2_q, x3_q, e_q;
	logic [DEN_W-1:0] den_q;
	logic signed [33:0] chg_q;
	logic [31:0] q1_q, temp_q, q2_q, nvel_q, q3_q;

	// Multiplier and divider datapath registers.
	logic [31:0] ma_q, mlo_q;
	logic [33:0] ma3_q;
	logic [32:0] mhi_q;
	logic        mneg_q;
	logic [DW-1:0] dvd_q, quot_q;
	logic [DEN_W-1:0] rem_q, dvs_q;

	logic out_valid_q, pinned_q;
	logic [31:0] npos_q, nvel_out_q;

	// Operands derived from the stored step values.
	logic [31:0] chg_s, a1, a2, a3;
	always_comb begin
		chg_s = sat32(64'(chg_q));
		a1 = sat32(64'($signed(vel_q)) + 64'($signed(q1_q)));
		a2 = sat32(64'($signed(vel_q)) - 64'($signed(q2_q)));
		a3 = sat32(64'($signed(chg_s)) + 64'($signed(temp_q)));
	end

	// Operand selection for the next operation.
	logic [31:0] ld_a, ld_b;
	logic        ld_neg, ld_div;
	logic [DW-1:0] ld_dvd;
	logic [DEN_W-1:0] ld_dvs;
	always_comb begin
		ld_a = '0;
		ld_b = '0;
		ld_neg = 1'b0;
		ld_div = 1'b0;
		ld_dvd = DVD_OMEGA;
		ld_dvs = DEN_W'(st_q);
		unique case (op_q)
			OP_OMEGA: begin
				ld_div = 1'b1;
			end
			OP_X: begin
				ld_a = {1'b0, omega_q};
				ld_b = {1'b0, dt_q};
			end
			OP_X2: begin
				ld_a = {1'b0, x_q};
				ld_b = {1'b0, x_q};
			end
			OP_X3: begin
				ld_a = x2_q;
				ld_b = {1'b0, x_q};
			end
			OP_T1: begin
				ld_a = C48;
				ld_b = x2_q;
			end
			OP_T2: begin
				ld_a = C235;
				ld_b = x3_q;
			end
			OP_E: begin
				ld_div = 1'b1;
				ld_dvd = DVD_E;
				ld_dvs = den_q;
			end
			OP_MC: begin
				ld_a = {1'b0, max_speed_q};
				ld_b = {1'b0, st_q};
			end
			OP_Q1: begin
				ld_a = {1'b0, omega_q};
				ld_b = mag32(chg_s);
				ld_neg = chg_s[31];
			end
			OP_TEMP: begin
				ld_a = mag32(a1);
				ld_b = {1'b0, dt_q};
				ld_neg = a1[31];
			end
			OP_Q2: begin
				ld_a = {1'b0, omega_q};
				ld_b = mag32(temp_q);
				ld_neg = temp_q[31];
			end
			OP_NVEL: begin
				ld_a = mag32(a2);
				ld_b = e_q;
				ld_neg = a2[31];
			end
			OP_Q3: begin
				ld_a = mag32(a3);
				ld_b = e_q;
				ld_neg = a3[31];
			end
			default: begin
				ld_a = '0;
			end
		endcase
	end

	// One radix-4 multiplier digit.
	logic [33:0] m_add;
	logic [34:0] m_sum;
	always_comb begin
		case (mlo_q[1:0])
			2'd0: m_add = '0;
			2'd1: m_add = {2'b00, ma_q};
			2'd2: m_add = {1'b0, ma_q, 1'b0};
			default: m_add = ma3_q;
		endcase
		m_sum = {2'b00, mhi_q} + {1'b0, m_add};
	end

	// One restoring divider step.
	logic [DEN_W-1:0] d_r2;
	logic d_ge;
	always_comb begin
		d_r2 = {rem_q[DEN_W-2:0], dvd_q[DW-1]};
		d_ge = (d_r2 >= dvs_q);
	end

	// Post-processing of the finished product.
	logic [63:0] prod, mag;
	logic [31:0] qres;
	always_comb begin
		prod = {mhi_q[31:0], mlo_q};
		mag = prod >> FRAC_BITS;
		if (mneg_q) begin
			qres = (mag > 64'h8000_0000) ? S32_MIN : (32'd0 - mag[31:0]);
		end else begin
			qres = (mag > 64'h7FFF_FFFF) ? S32_MAX : mag[31:0];
		end
	end

	// Final position and the overshoot test.
	logic signed [63:0] lim_tgt;
	logic [31:0] npos;
	logic pin;
	always_comb begin
		lim_tgt = 64'($signed(cur_q)) - 64'(chg_q);
		npos = sat32(lim_tgt + 64'($signed(q3_q)));
		pin = ($signed(tgt_q) > $signed(cur_q)) == ($signed(npos) > $signed(tgt_q));
	end

	// The finished step moves into the output register when it is free.
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign new_pos = npos_q;
	assign new_velocity = nvel_out_q;
	assign overshoot_pinned = pinned_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_time_q <= 31'(ONE_L);
			max_speed_q <= U31_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SMOOTH_TIME: smooth_time_q <= cfg_data;
				CFG_MAX_SPEED: max_speed_q <= cfg_data;
				default: max_speed_q <= max_speed_q;
			endcase
		end
	end

	// Control: sequencer, velocity and output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_OMEGA;
			cnt_q <= '0;
			vel_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= OP_OMEGA;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (ld_div) begin
						cnt_q <= CNT_W'(DW - 1);
						state_q <= ST_DIV;
					end else begin
						cnt_q <= CNT_W'(MUL_DIGITS - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL, ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (op_q == OP_Q3) begin
						state_q <= ST_OUT;
					end else begin
						op_q <= op_t'(op_q + 4'd1);
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						vel_q <= pin ? 32'd0 : nvel_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q <= current_pos;
				tgt_q <= target_pos;
				dt_q <= time_step;
				st_q <= (smooth_time_q < MIN_ST) ? MIN_ST : smooth_time_q;
				chg_q <= 34'(current_pos) - 34'(target_pos);
			end
			ST_LOAD: begin
				ma_q <= ld_a;
				ma3_q <= {2'b00, ld_a} + {1'b0, ld_a, 1'b0};
				mlo_q <= ld_b;
				mhi_q <= '0;
				mneg_q <= ld_neg;
				dvd_q <= ld_dvd;
				dvs_q <= ld_dvs;
				rem_q <= '0;
				quot_q <= '0;
			end
			ST_MUL: begin
				mhi_q <= m_sum[34:2];
				mlo_q <= {m_sum[1:0], mlo_q[31:2]};
			end
			ST_DIV: begin
				rem_q <= d_ge ? (d_r2 - dvs_q) : d_r2;
				quot_q <= {quot_q[DW-2:0], d_ge};
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
			ST_WB: begin
				unique case (op_q)
					OP_OMEGA: omega_q <= (quot_q > DW'(U31_MAX)) ? U31_MAX : quot_q[30:0];
					OP_X: x_q <= (mag > 64'(U31_MAX)) ? U31_MAX : mag[30:0];
					OP_X2: x2_q <= (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
					OP_X3: x3_q <= (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
					OP_T1: den_q <= ONE_D + DEN_W'(x_q) + mag[DEN_W-1:0];
					OP_T2: den_q <= den_q + mag[DEN_W-1:0];
					OP_E: e_q <= quot_q[31:0];
					OP_MC: begin
						if (max_speed_q != U31_MAX) begin
							if (64'(chg_q) > $signed(mag)) begin
								chg_q <= mag[33:0];
							end else if (64'(chg_q) < -$signed(mag)) begin
								chg_q <= 34'd0 - mag[33:0];
							end
						end
					end
					OP_Q1: q1_q <= qres;
					OP_TEMP: temp_q <= qres;
					OP_Q2: q2_q <= qres;
					OP_NVEL: nvel_q <= qres;
					OP_Q3: q3_q <= qres;
					default: q3_q <= qres;
				endcase
			end
			ST_OUT: begin
				if (out_load) begin
					npos_q <= pin ? tgt_q : npos;
					nvel_out_q <= pin ? 32'd0 : nvel_q;
					pinned_q <= pin;
				end
			end
			default: begin
				mneg_q <= mneg_q;
			end
		endcase
	end

endmodule
